>>> sv/cabad_pkg.sv
// Package: shared types, command codes and decoding tables for the CABAC decoder unit.
`default_nettype none

package cabad_pkg;

  // command codes
  localparam logic [2:0] CMD_START     = 3'd0;
  localparam logic [2:0] CMD_WRITE_CTX = 3'd1;
  localparam logic [2:0] CMD_REGULAR   = 3'd2;
  localparam logic [2:0] CMD_BYPASS    = 3'd3;
  localparam logic [2:0] CMD_TERMINATE = 3'd4;

  localparam logic [8:0] RANGE_INIT    = 9'd510;
  localparam logic [3:0] BITS_INIT     = 4'b1000;  // -8, two's complement
  localparam logic [3:0] BITS_LAST     = 4'b1111;  // -1: next shift pulls a byte
  localparam logic [8:0] TERM_RANGE_DEC = 9'd2;
  localparam logic [5:0] STATE_SAT     = 6'd62;

  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  ctx_index;
    logic [6:0]  ctx_value;
    logic [7:0]  next_byte;
    logic [15:0] start_word;
  } cabad_in_t;

  typedef struct packed {
    logic bin;
    logic byte_consumed;
  } cabad_out_t;

  // arithmetic state; bits_needed is 4-bit two's complement, always -8..-1
  typedef struct packed {
    logic [8:0]  range_val;
    logic [16:0] offset;
    logic [3:0]  bits_needed;
  } cabad_state_t;

  typedef struct packed {
    logic       en;
    logic [5:0] index;
    logic [6:0] value;
  } cabad_ctx_wr_t;

  localparam int unsigned LPS_TABLE [64][4] = '{
    '{128,176,208,240}, '{128,167,197,227}, '{128,158,187,216}, '{123,150,178,205},
    '{116,142,169,195}, '{111,135,160,185}, '{105,128,152,175}, '{100,122,144,166},
    '{95,116,137,158},  '{90,110,130,150},  '{85,104,123,142},  '{81,99,117,135},
    '{77,94,111,128},   '{73,89,105,122},   '{69,85,100,116},   '{66,80,95,110},
    '{62,76,90,104},    '{59,72,86,99},     '{56,69,81,94},     '{53,65,77,89},
    '{51,62,73,85},     '{48,59,69,80},     '{46,56,66,76},     '{43,53,63,72},
    '{41,50,59,69},     '{39,48,56,65},     '{37,45,54,62},     '{35,43,51,59},
    '{33,41,48,56},     '{32,39,46,53},     '{30,37,43,50},     '{29,35,41,48},
    '{27,33,39,45},     '{26,31,37,43},     '{24,30,35,41},     '{23,28,33,39},
    '{22,27,32,37},     '{21,26,30,35},     '{20,24,29,33},     '{19,23,27,31},
    '{18,22,26,30},     '{17,21,25,28},     '{16,20,23,27},     '{15,19,22,25},
    '{14,18,21,24},     '{14,17,20,23},     '{13,16,19,22},     '{12,15,18,21},
    '{12,14,17,20},     '{11,14,16,19},     '{11,13,15,18},     '{10,12,15,17},
    '{10,12,14,16},     '{9,11,13,15},      '{9,11,12,14},      '{8,10,12,14},
    '{8,9,11,13},       '{7,9,11,12},       '{7,9,10,12},       '{7,8,10,11},
    '{6,8,9,11},        '{6,7,9,10},        '{6,7,8,9},         '{2,2,2,2}
  };

  localparam int unsigned RENORM_SHIFT [32] = '{
    6,5,4,4,3,3,3,3,2,2,2,2,2,2,2,2,
    1,1,1,1,1,1,1,1,1,1,1,1,1,1,1,1
  };

  localparam int unsigned LPS_NEXT [64] = '{
    0,0,1,2,2,4,4,5,6,7,8,9,9,11,11,12,
    13,13,15,15,16,16,18,18,19,19,21,21,22,22,23,24,
    24,25,26,26,27,27,28,29,29,30,30,30,31,32,32,33,
    33,33,34,34,35,35,35,36,36,36,37,37,37,38,38,63
  };

endpackage

`default_nettype wire

>>> sv/cabad_ctx_mem.sv
// Context word memory with registered read and write-to-read forwarding.
`default_nettype none

module cabad_ctx_mem #(
  parameter int NUM_CONTEXTS = 64
) (
  input  wire                      clk,
  input  wire                      rd_en,
  input  wire [5:0]                rd_index,
  input  cabad_pkg::cabad_ctx_wr_t wr,
  output logic [6:0]               rd_word
);
  import cabad_pkg::*;

  localparam int AW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

  logic [6:0]    mem [NUM_CONTEXTS];
  logic [6:0]    rd_word_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          rd_ok;
  logic          wr_ok;
  logic          fwd;

  assign rd_addr = AW'(rd_index);
  assign wr_addr = AW'(wr.index);
  assign rd_ok   = 32'(rd_index) < 32'(NUM_CONTEXTS);
  assign wr_ok   = wr.en && (32'(wr.index) < 32'(NUM_CONTEXTS));
  // word being written this cycle wins over the stale array entry
  assign fwd     = wr_ok && (wr.index == rd_index);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr.value;
    end
    if (rd_en) begin
      if (!rd_ok) begin
        rd_word_r <= '0;
      end else if (fwd) begin
        rd_word_r <= wr.value;
      end else begin
        rd_word_r <= mem[rd_addr];
      end
    end
  end

  assign rd_word = rd_word_r;

endmodule

`default_nettype wire

>>> sv/cabad_engine.sv
// Combinational arithmetic decoding core: next range, offset, bit count, bin and context word.
`default_nettype none

module cabad_engine (
  input  cabad_pkg::cabad_in_t     item,
  input  wire [6:0]                ctx_word,
  input  cabad_pkg::cabad_state_t  state,
  output cabad_pkg::cabad_state_t  state_nxt,
  output cabad_pkg::cabad_out_t    res,
  output cabad_pkg::cabad_ctx_wr_t ctx_wr
);
  import cabad_pkg::*;

  // regular bin terms
  logic [5:0]  st;
  logic        mps;
  logic [7:0]  lps;
  logic [8:0]  lps9;
  logic [8:0]  rng_mps;
  logic [15:0] scaled_mps;
  logic        is_mps;
  logic [2:0]  nshift;
  logic [16:0] off_diff;
  logic [4:0]  bits_sum;
  logic [5:0]  st_mps;
  logic [5:0]  st_lps;
  // shared one-bit renormalization
  logic [16:0] off_sh1;
  logic        last_bit;
  logic [3:0]  bits_inc;
  // bypass and terminate terms
  logic [16:0] byp_off;
  logic [15:0] scaled_cur;
  logic [8:0]  rng_term;
  logic [15:0] scaled_term;

  assign st         = ctx_word[6:1];
  assign mps        = ctx_word[0];
  assign lps        = 8'(LPS_TABLE[st][state.range_val[7:6]]);
  assign lps9       = {1'b0, lps};
  assign rng_mps    = state.range_val - lps9;
  assign scaled_mps = {rng_mps, 7'b0};
  assign is_mps     = state.offset < {1'b0, scaled_mps};
  assign nshift     = 3'(RENORM_SHIFT[lps[7:3]]);
  assign off_diff   = state.offset - {1'b0, scaled_mps};
  assign bits_sum   = {state.bits_needed[3], state.bits_needed} + {2'b00, nshift};
  assign st_mps     = (st < STATE_SAT) ? st + 6'd1 : st;
  assign st_lps     = 6'(LPS_NEXT[st]);

  assign off_sh1    = {state.offset[15:0], 1'b0};
  assign last_bit   = state.bits_needed == BITS_LAST;
  assign bits_inc   = last_bit ? BITS_INIT : state.bits_needed + 4'd1;

  assign byp_off    = last_bit ? off_sh1 + {9'b0, item.next_byte} : off_sh1;
  assign scaled_cur = {state.range_val, 7'b0};

  assign rng_term    = state.range_val - TERM_RANGE_DEC;
  assign scaled_term = {rng_term, 7'b0};

  always_comb begin
    state_nxt    = state;
    res          = '0;
    ctx_wr       = '0;
    ctx_wr.index = item.ctx_index;
    unique case (item.command)
      CMD_START: begin
        state_nxt.range_val   = RANGE_INIT;
        state_nxt.bits_needed = BITS_INIT;
        state_nxt.offset      = {1'b0, item.start_word};
      end
      CMD_WRITE_CTX: begin
        ctx_wr.en    = 1'b1;
        ctx_wr.value = item.ctx_value;
      end
      CMD_REGULAR: begin
        ctx_wr.en = 1'b1;
        if (is_mps) begin
          res.bin             = mps;
          ctx_wr.value        = {st_mps, mps};
          state_nxt.range_val = rng_mps;
          if (!rng_mps[8]) begin
            state_nxt.range_val   = {rng_mps[7:0], 1'b0};
            state_nxt.bits_needed = bits_inc;
            state_nxt.offset      = last_bit ? off_sh1 + {9'b0, item.next_byte} : off_sh1;
            res.byte_consumed     = last_bit;
          end
        end else begin
          res.bin             = ~mps;
          ctx_wr.value        = {st_lps, (st == 6'd0) ? ~mps : mps};
          state_nxt.range_val = lps9 << nshift;
          state_nxt.offset    = off_diff << nshift;
          state_nxt.bits_needed = bits_sum[3:0];
          if (!bits_sum[4]) begin
            // bit count reached zero or above: byte lands at that position
            state_nxt.offset      = (off_diff << nshift)
                                  + 17'({9'b0, item.next_byte} << bits_sum[2:0]);
            state_nxt.bits_needed = 4'(bits_sum - 5'd8);
            res.byte_consumed     = 1'b1;
          end
        end
      end
      CMD_BYPASS: begin
        state_nxt.bits_needed = bits_inc;
        res.byte_consumed     = last_bit;
        state_nxt.offset      = byp_off;
        if (byp_off >= {1'b0, scaled_cur}) begin
          res.bin          = 1'b1;
          state_nxt.offset = byp_off - {1'b0, scaled_cur};
        end
      end
      CMD_TERMINATE: begin
        state_nxt.range_val = rng_term;
        if (state.offset >= {1'b0, scaled_term}) begin
          res.bin = 1'b1;
        end else if (!rng_term[8]) begin
          state_nxt.range_val   = {rng_term[7:0], 1'b0};
          state_nxt.bits_needed = bits_inc;
          state_nxt.offset      = last_bit ? off_sh1 + {9'b0, item.next_byte} : off_sh1;
          res.byte_consumed     = last_bit;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/cabac_binary_arithmetic_decoder_unit.sv
// Top level: CABAC binary arithmetic decoder with input register, core and result register.
//
//   channel  | direction | handshake            | word
//   ---------+-----------+----------------------+-------------------------------
//   in_      | in        | in_valid / in_ready  | cabad_in_t (command, ctx, byte)
//   out_     | out       | out_valid / out_ready| cabad_out_t (bin, byte_consumed)
//
// One word per cycle while out_ready stays high; out_valid is set when stage 1 fires.
// The critical path is the context read register -> LPS table -> range subtract ->
// offset compare -> renormalize shift -> state and result registers.
// The context memory is read at accept; a write from the word in flight is forwarded.
// Synchronous active-low reset sets range 510, offset 0, bit count -8; contexts keep
// their contents. A stalled result holds the input stage; no state moves until it drains.
`default_nettype none

module cabac_binary_arithmetic_decoder_unit #(
  parameter int NUM_CONTEXTS = 64
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  cabad_pkg::cabad_in_t   in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output cabad_pkg::cabad_out_t  out_data
);
  import cabad_pkg::*;

  // input stage
  logic          s1_valid_r;
  logic          s1_valid_nxt;
  cabad_in_t     s1_item_r;
  logic [6:0]    ctx_word;

  // architectural decoder state
  cabad_state_t  state_r;
  cabad_state_t  state_nxt;

  // result stage
  logic          out_valid_r;
  logic          out_valid_nxt;
  cabad_out_t    out_data_r;
  cabad_out_t    eng_res;
  cabad_ctx_wr_t eng_wr;
  cabad_ctx_wr_t mem_wr;

  logic          in_acc;
  logic          fire;      // word in stage 1 is decoded and committed this cycle

  assign fire      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || fire;
  assign in_acc    = in_valid && in_ready;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !fire);
  assign out_valid_nxt = fire || (out_valid_r && !out_ready);

  // context writes commit only when the word actually retires
  always_comb begin
    mem_wr    = eng_wr;
    mem_wr.en = eng_wr.en && fire;
  end

  cabad_ctx_mem #(
    .NUM_CONTEXTS (NUM_CONTEXTS)
  ) u_ctx_mem (
    .clk      (clk),
    .rd_en    (in_acc),
    .rd_index (in_data.ctx_index),
    .wr       (mem_wr),
    .rd_word  (ctx_word)
  );

  cabad_engine u_engine (
    .item      (s1_item_r),
    .ctx_word  (ctx_word),
    .state     (state_r),
    .state_nxt (state_nxt),
    .res       (eng_res),
    .ctx_wr    (eng_wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
      state_r.range_val     <= RANGE_INIT;
      state_r.offset        <= '0;
      state_r.bits_needed   <= BITS_INIT;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (fire) begin
      out_data_r <= eng_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // bit count never leaves -8..-1
  a_bits_negative: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bits_needed[3] == 1'b1)
    else $error("bits_needed left its negative range");

  // every retired word shows up as a result
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("retired word produced no result");

  // state only moves when a word retires
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(state_r))
    else $error("decoder state changed without a retiring word");

  // with an empty result stage the input side is never blocked
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result stage");
`endif

endmodule

`default_nettype wire

>>> bench/tb_cabac_binary_arithmetic_decoder_unit.sv
// Self-checking testbench for the CABAC binary arithmetic decoder unit.
`timescale 1ns / 100ps

module tb_cabac_binary_arithmetic_decoder_unit;
  import cabad_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 4;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 8;      // input and result register stages plus margin
  localparam int HOLD_CYCLES    = 250;    // long receiver hold-off
  localparam int HOLD_AT_FIRST  = 400;
  localparam int HOLD_AT_SECOND = 900;

  localparam int unsigned RANGE_MASK   = 32'h1FF;
  localparam int unsigned OFFSET_MASK  = 32'h1FFFF;
  localparam int unsigned RENORM_LIMIT = 256 << 7;
  localparam int unsigned WELL_FORMED_MAX = 65279;  // start word below 510 << 7

  // clock, reset and DUT-facing signals; the bench-driven ones are known from time zero
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  cabad_in_t  in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  cabad_out_t out_data;

  cabac_binary_arithmetic_decoder_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // words waiting to be offered, and decoded results still owed by the DUT
  cabad_in_t  pending_words[$];
  cabad_out_t expected_bins[$];

  int error_cnt   = 0;
  int cycle_cnt   = 0;
  int results_cnt = 0;

  // ---------------------------------------------------------------------------
  // Decoder model: arithmetic state and context memory at the block's widths.
  // Updated once per accepted input word.
  // ---------------------------------------------------------------------------
  logic [8:0]        rng_q  = RANGE_INIT;
  logic [16:0]       ofs_q  = '0;
  logic signed [3:0] bits_q = BITS_INIT;
  logic [6:0]        ctx_model [64];

  function automatic cabad_out_t decode_predict(input cabad_in_t w);
    cabad_out_t  res;
    int unsigned st, mps, lps, scaled, n, rng_v, ofs_v, nb;
    int          bits_v;
    res    = '0;
    rng_v  = 32'(rng_q);
    ofs_v  = 32'(ofs_q);
    bits_v = int'(bits_q);
    nb     = 32'(w.next_byte);
    case (w.command)
      CMD_START: begin
        // contexts survive a start; the byte is never taken here
        rng_v  = 32'(RANGE_INIT);
        bits_v = int'($signed(BITS_INIT));
        ofs_v  = 32'(w.start_word);
      end
      CMD_WRITE_CTX: begin
        ctx_model[w.ctx_index] = w.ctx_value;
      end
      CMD_REGULAR: begin
        st     = 32'(ctx_model[w.ctx_index][6:1]);
        mps    = 32'(ctx_model[w.ctx_index][0]);
        lps    = LPS_TABLE[st][(rng_v >> 6) & 3];
        rng_v  = (rng_v - lps) & RANGE_MASK;
        scaled = rng_v << 7;
        if (ofs_v < scaled) begin
          // MPS path: at most one bit of renormalization
          res.bin = mps[0];
          if (st < STATE_SAT) st++;
          if (scaled < RENORM_LIMIT) begin
            rng_v  = (scaled >> 6) & RANGE_MASK;
            ofs_v  = (ofs_v << 1) & OFFSET_MASK;
            bits_v = bits_v + 1;
            if (bits_v >= 0) begin
              bits_v = int'($signed(BITS_INIT));
              ofs_v  = (ofs_v + nb) & OFFSET_MASK;
              res.byte_consumed = 1'b1;
            end
          end
        end else begin
          // LPS path: table-driven shift, byte lands at the current bit position
          n       = RENORM_SHIFT[(lps >> 3) & 31];
          ofs_v   = ((ofs_v - scaled) << n) & OFFSET_MASK;
          rng_v   = (lps << n) & RANGE_MASK;
          res.bin = ~mps[0];
          if (st == 0) mps = mps ^ 1;
          st      = LPS_NEXT[st & 63];
          bits_v  = bits_v + int'(n);
          if (bits_v >= 0) begin
            ofs_v  = (ofs_v + (nb << bits_v)) & OFFSET_MASK;
            bits_v = bits_v - 8;
            res.byte_consumed = 1'b1;
          end
        end
        ctx_model[w.ctx_index] = {st[5:0], mps[0]};
      end
      CMD_BYPASS: begin
        ofs_v  = (ofs_v << 1) & OFFSET_MASK;
        bits_v = bits_v + 1;
        if (bits_v >= 0) begin
          bits_v = int'($signed(BITS_INIT));
          ofs_v  = (ofs_v + nb) & OFFSET_MASK;
          res.byte_consumed = 1'b1;
        end
        scaled = rng_v << 7;
        if (ofs_v >= scaled) begin
          res.bin = 1'b1;
          ofs_v   = (ofs_v - scaled) & OFFSET_MASK;
        end
      end
      CMD_TERMINATE: begin
        rng_v  = (rng_v - TERM_RANGE_DEC) & RANGE_MASK;
        scaled = rng_v << 7;
        if (ofs_v >= scaled) begin
          res.bin = 1'b1;
        end else if (scaled < RENORM_LIMIT) begin
          rng_v  = (scaled >> 6) & RANGE_MASK;
          ofs_v  = (ofs_v << 1) & OFFSET_MASK;
          bits_v = bits_v + 1;
          if (bits_v >= 0) begin
            bits_v = int'($signed(BITS_INIT));
            ofs_v  = (ofs_v + nb) & OFFSET_MASK;
            res.byte_consumed = 1'b1;
          end
        end
      end
      default: begin
        // unused codes: no state change, zero result
      end
    endcase
    rng_q  = rng_v[8:0];
    ofs_q  = ofs_v[16:0];
    bits_q = bits_v[3:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building. Regular bins only ever name a context that has been
  // written earlier in the stream.
  // ---------------------------------------------------------------------------
  bit ctx_written [64];
  int written_idx [$];
  int stim_cnt = 0;

  task automatic push_word(input logic [2:0] cmd, input logic [5:0] idx,
                           input logic [6:0] val, input logic [7:0] nb,
                           input logic [15:0] sw);
    cabad_in_t w;
    w.command    = cmd;
    w.ctx_index  = idx;
    w.ctx_value  = val;
    w.next_byte  = nb;
    w.start_word = sw;
    pending_words.push_back(w);
    if (cmd <= CMD_TERMINATE) stim_cnt++;
  endtask

  task automatic write_ctx(input logic [5:0] idx, input logic [6:0] val);
    push_word(CMD_WRITE_CTX, idx, val, 8'($urandom), 16'($urandom));
    if (!ctx_written[idx]) begin
      ctx_written[idx] = 1'b1;
      written_idx.push_back(int'(idx));
    end
  endtask

  task automatic regular_bin(input logic [7:0] nb);
    int idx;
    idx = written_idx[$urandom_range(0, written_idx.size() - 1)];
    push_word(CMD_REGULAR, 6'(idx), 7'($urandom), nb, 16'($urandom));
  endtask

  task automatic build_stimulus();
    int nbins, r;
    logic [2:0] cmd;
    // --- directed ---
    push_word(CMD_TERMINATE, 6'd0, 7'd0, 8'h00, 16'h0000);  // terminate straight out of reset
    write_ctx(6'd0, 7'd0);       // state 0, MPS 0: LPS flips MPS
    write_ctx(6'd63, 7'd127);    // state 63, MPS 1: fixed tiny LPS range
    write_ctx(6'd1, 7'd125);     // state 62, MPS 1: saturation
    write_ctx(6'd2, 7'd1);
    push_word(CMD_START, 6'd0, 7'd0, 8'h00, 16'h0000);
    regular_bin(8'hFF);
    push_word(CMD_REGULAR, 6'd63, 7'd0, 8'hFF, 16'h0000);
    push_word(CMD_REGULAR, 6'd1, 7'd0, 8'h00, 16'h0000);
    push_word(CMD_START, 6'd63, 7'd127, 8'hFF, 16'hFFFF);   // offset above scaled range
    push_word(CMD_REGULAR, 6'd0, 7'd127, 8'hFF, 16'hFFFF);
    push_word(CMD_REGULAR, 6'd1, 7'd127, 8'h00, 16'hFFFF);
    push_word(CMD_BYPASS, 6'd0, 7'd0, 8'hFF, 16'h0000);
    push_word(CMD_TERMINATE, 6'd0, 7'd0, 8'h00, 16'h0000);
    push_word(CMD_BYPASS, 6'd0, 7'd0, 8'h00, 16'h0000);    // decoding on after a terminate
    push_word(CMD_START, 6'd0, 7'd0, 8'h00, 16'h8000);
    repeat (8) push_word(CMD_BYPASS, 6'd0, 7'd0, 8'hA5, 16'h0000);  // bypass run pulls a byte
    push_word(CMD_REGULAR, 6'd2, 7'd0, 8'h5A, 16'h0000);
    push_word(CMD_REGULAR, 6'd2, 7'd0, 8'hC3, 16'h0000);
    push_word(3'd5, 6'd63, 7'd127, 8'hFF, 16'hFFFF);       // unused codes
    push_word(3'd6, 6'd0, 7'd0, 8'h00, 16'h0000);
    push_word(3'd7, 6'd63, 7'd127, 8'hFF, 16'hFFFF);
    // --- random: mostly start followed by a run of bins, some noise ---
    while (stim_cnt < RANDOM_ITEMS + 25) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 9) == 0)
          push_word(CMD_START, 6'($urandom), 7'($urandom), 8'($urandom), 16'($urandom));
        else
          push_word(CMD_START, 6'($urandom), 7'($urandom), 8'($urandom),
                    16'($urandom_range(0, WELL_FORMED_MAX)));
        nbins = $urandom_range(4, 40);
        repeat (nbins) begin
          r = $urandom_range(0, 99);
          if (r < 60)      regular_bin(8'($urandom));
          else if (r < 85) push_word(CMD_BYPASS, 6'($urandom), 7'($urandom), 8'($urandom),
                                     16'($urandom));
          else if (r < 92) push_word(CMD_TERMINATE, 6'($urandom), 7'($urandom),
                                     8'($urandom), 16'($urandom));
          else             write_ctx(6'($urandom), 7'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          cmd = 3'($urandom_range(0, 7));
          if (cmd == CMD_REGULAR)        regular_bin(8'($urandom));
          else if (cmd == CMD_WRITE_CTX) write_ctx(6'($urandom), 7'($urandom));
          else push_word(cmd, 6'($urandom), 7'($urandom), 8'($urandom), 16'($urandom));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps. A word stays put until taken.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_bins.push_back(decode_predict(in_data));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_data  <= pending_words.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // new burst; long gap-free stretches come from the big bursts
            burst_left = $urandom_range(1, 60);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result word against the oldest prediction, and drives
  // out_ready from its own stall pattern plus two long hold-offs.
  // ---------------------------------------------------------------------------
  int hold_left  = 0;
  int rx_mode    = 0;
  int rx_phase   = 0;
  cabad_out_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_bins.size() == 0) begin
          $display("%0t: unexpected result word bin=%0d byte_consumed=%0d",
                   $time, out_data.bin, out_data.byte_consumed);
          error_cnt++;
        end else begin
          want = expected_bins.pop_front();
          if (out_data.bin !== want.bin) begin
            $display("%0t: bin mismatch, expected %0d actual %0d",
                     $time, want.bin, out_data.bin);
            error_cnt++;
          end
          if (out_data.byte_consumed !== want.byte_consumed) begin
            $display("%0t: byte_consumed mismatch, expected %0d actual %0d",
                     $time, want.byte_consumed, out_data.byte_consumed);
            error_cnt++;
          end
        end
        results_cnt++;
        if (results_cnt == HOLD_AT_FIRST || results_cnt == HOLD_AT_SECOND)
          hold_left = HOLD_CYCLES;
      end
      rx_phase++;
      if (rx_phase % 50 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        // back-pressure long enough to fill the pipe and drop in_ready
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((rx_phase % 4) != 3);
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_cabac_binary_arithmetic_decoder_unit NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the stream, release reset, wait for the pipe to empty.
  // ---------------------------------------------------------------------------
  initial begin
    build_stimulus();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_words.size() != 0 || in_valid || expected_bins.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_cnt == 0) begin
      $display("tb_cabac_binary_arithmetic_decoder_unit OK");
    end else begin
      $display("tb_cabac_binary_arithmetic_decoder_unit NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
sv/cabad_pkg.sv
sv/cabad_ctx_mem.sv
sv/cabad_engine.sv
sv/cabac_binary_arithmetic_decoder_unit.sv
bench/tb_cabac_binary_arithmetic_decoder_unit.sv
